/* rtl/sdq_pkg.sv */
// ----------------------------------------------------------------------------
// sdq_pkg
// Shared types and constants of the sorted deadline queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sdq_pkg;

  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned MaxResults    = 16;

  localparam int unsigned TimeW  = 48;
  localparam int unsigned DelayW = 32;
  localparam int unsigned IdW    = 16;
  localparam int unsigned ScaleW = 10;
  localparam int unsigned ProdW  = DelayW + ScaleW;

  localparam logic [ScaleW-1:0] UsPerMs = ScaleW'(1000);

  typedef enum logic [1:0] {
    ST_REGISTERED = 2'd0,
    ST_FULL       = 2'd1,
    ST_EXPIRED    = 2'd2,
    ST_NONE       = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_INS,
    S_DRAIN
  } state_e;

  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/sdq_cell.sv */
// ----------------------------------------------------------------------------
// sdq_cell
// One slot of the sorted chain: holds a deadline and handle, compares
// against the broadcast key, and shifts right on insert or left on pop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdq_cell (
  input  wire                       clk_i,
  input  wire                       valid_i,
  input  wire sdq_pkg::cell_ctrl_t  ctrl_i,
  input  wire [sdq_pkg::TimeW-1:0]  key_i,
  input  wire [sdq_pkg::IdW-1:0]    new_id_i,
  input  wire                       prev_open_i,
  input  wire [sdq_pkg::TimeW-1:0]  prev_deadline_i,
  input  wire [sdq_pkg::IdW-1:0]    prev_id_i,
  input  wire [sdq_pkg::TimeW-1:0]  next_deadline_i,
  input  wire [sdq_pkg::IdW-1:0]    next_id_i,
  output logic                      le_o,
  output logic [sdq_pkg::TimeW-1:0] deadline_o,
  output logic [sdq_pkg::IdW-1:0]   id_o
);
  import sdq_pkg::*;

  logic [TimeW-1:0] deadline_q, deadline_d;
  logic [IdW-1:0]   id_q, id_d;

  assign le_o       = valid_i && (deadline_q <= key_i);
  assign deadline_o = deadline_q;
  assign id_o       = id_q;

  always_comb begin
    deadline_d = deadline_q;
    id_d       = id_q;
    if (ctrl_i.ins && !le_o) begin
      if (prev_open_i) begin
        deadline_d = prev_deadline_i;
        id_d       = prev_id_i;
      end else begin
        deadline_d = key_i;
        id_d       = new_id_i;
      end
    end else if (ctrl_i.pop) begin
      deadline_d = next_deadline_i;
      id_d       = next_id_i;
    end
  end

  always_ff @(posedge clk_i) begin
    deadline_q <= deadline_d;
    id_q       <= id_d;
  end

endmodule

`default_nettype wire

/* rtl/sorted_deadline_queue_unit.sv */
// ----------------------------------------------------------------------------
// sorted_deadline_queue_unit
// Bounded alarm queue kept in ascending deadline order in a chain of cells.
// ----------------------------------------------------------------------------
// Register: scale the delay in S_MUL, then in S_INS, once the output is free,
//   insert into the chain and issue the result; next item accepted in S_IDLE.
// Check: one expired handle per cycle while the output is not stalled, as
//   the chain shifts left; next item taken once the last is issued.
// Reset clears the entry count and output valid; cell contents are not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_deadline_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = sdq_pkg::QueueDepthDef
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  wire                        cmd_i,
  input  wire [sdq_pkg::TimeW-1:0]   now_us_i,
  input  wire [sdq_pkg::DelayW-1:0]  delay_ms_i,
  input  wire [sdq_pkg::IdW-1:0]     alarm_id_i,
  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  output logic [1:0]                 status_o,
  output logic [sdq_pkg::IdW-1:0]    expired_id_o,
  output logic                       last_o
);
  import sdq_pkg::*;

  localparam int unsigned CntW   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned DrainW = $clog2(MaxResults + 1);

  state_e state_q, state_d;

  logic [TimeW-1:0]  now_q;
  logic [DelayW-1:0] delay_q;
  logic [IdW-1:0]    id_q;
  logic [ProdW-1:0]  prod_q;
  logic [CntW-1:0]   count_q, count_d;
  logic [DrainW-1:0] drain_q, drain_d;

  logic              out_valid_q;
  status_e           status_q, status_d;
  logic [IdW-1:0]    out_id_q, out_id_d;
  logic              last_q, last_d;

  logic              accept;
  logic              out_free;
  logic              emit;
  logic              full;
  logic [TimeW:0]    sum;
  logic [TimeW-1:0]  deadline;
  logic [TimeW-1:0]  key;
  cell_ctrl_t        ctrl;

  logic              le_w   [QUEUE_DEPTH];
  logic [TimeW-1:0]  dl_w   [QUEUE_DEPTH];
  logic [IdW-1:0]    hid_w  [QUEUE_DEPTH];

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign full     = (count_q == CntW'(QUEUE_DEPTH));
  assign sum      = {1'b0, now_q} + (TimeW + 1)'(prod_q);
  assign deadline = sum[TimeW] ? {TimeW{1'b1}} : sum[TimeW-1:0];
  assign key      = (state_q == S_DRAIN) ? now_q : deadline;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = cmd_i ? S_DRAIN : S_MUL;
      S_MUL:   state_d = S_INS;
      S_INS:   if (out_free) state_d = S_IDLE;
      S_DRAIN: if (out_free && last_d) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs and chain control
  always_comb begin
    in_ready_o = 1'b0;
    emit       = 1'b0;
    ctrl       = '0;
    status_d   = ST_NONE;
    out_id_d   = '0;
    last_d     = 1'b1;
    drain_d    = drain_q;
    count_d    = count_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        drain_d    = '0;
      end
      S_MUL: ;
      S_INS: begin
        status_d = full ? ST_FULL : ST_REGISTERED;
        if (out_free) begin
          emit     = 1'b1;
          ctrl.ins = !full;
          if (!full) count_d = count_q + CntW'(1);
        end
      end
      S_DRAIN: begin
        if (le_w[0]) begin
          status_d = ST_EXPIRED;
          out_id_d = hid_w[0];
          last_d   = !le_w[1] || (drain_q == DrainW'(MaxResults - 1));
        end
        if (out_free) begin
          emit = 1'b1;
          if (le_w[0]) begin
            ctrl.pop = 1'b1;
            count_d  = count_q - CntW'(1);
            drain_d  = drain_q + DrainW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      drain_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      drain_q <= drain_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q   <= now_us_i;
      delay_q <= delay_ms_i;
      id_q    <= alarm_id_i;
    end
    if (state_q == S_MUL) begin
      prod_q <= ProdW'(delay_q) * ProdW'(UsPerMs);
    end
    if (emit) begin
      status_q <= status_d;
      out_id_q <= out_id_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign expired_id_o = out_id_q;
  assign last_o       = last_q;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic             prev_open;
    logic [TimeW-1:0] prev_dl;
    logic [IdW-1:0]   prev_id;
    logic [TimeW-1:0] next_dl;
    logic [IdW-1:0]   next_id;

    if (i == 0) begin : g_head
      assign prev_open = 1'b0;
      assign prev_dl   = key;
      assign prev_id   = id_q;
    end else begin : g_body
      assign prev_open = !le_w[i-1];
      assign prev_dl   = dl_w[i-1];
      assign prev_id   = hid_w[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_dl = dl_w[i];
      assign next_id = hid_w[i];
    end else begin : g_inner
      assign next_dl = dl_w[i+1];
      assign next_id = hid_w[i+1];
    end

    sdq_cell u_cell (
      .clk_i           (clk_i),
      .valid_i         (CntW'(i) < count_q),
      .ctrl_i          (ctrl),
      .key_i           (key),
      .new_id_i        (id_q),
      .prev_open_i     (prev_open),
      .prev_deadline_i (prev_dl),
      .prev_id_i       (prev_id),
      .next_deadline_i (next_dl),
      .next_id_i       (next_id),
      .le_o            (le_w[i]),
      .deadline_o      (dl_w[i]),
      .id_o            (hid_w[i])
    );
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("entry count exceeds capacity");

  a_pop_expired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.pop |-> (le_w[0] && count_q != '0))
    else $error("pop of an unexpired or empty head");

  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins |=> count_q == $past(count_q) + CntW'(1))
    else $error("insert did not advance count");

  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CntW'(2)) |-> (dl_w[0] <= dl_w[1]))
    else $error("head entries out of order");

  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl.ins && ctrl.pop))
    else $error("insert and pop together");

endmodule

`default_nettype wire
